// ===== sv/usv_pkg.sv =====
// Package for the UV-sphere vertex generator: word types, command and
// register codes, parameter defaults and the quarter-sine coefficients.
// No dependencies.
package usv_pkg;

  localparam int MAX_SEGMENTS_DEF = 1024;
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int SEG_W            = 10;
  localparam int IDX_W            = 20;
  localparam int TEX_W            = 17;
  localparam int POS_W            = 16;
  localparam int CFG_IDX_W        = 2;

  localparam logic CMD_VERTEX = 1'b0;
  localparam logic CMD_QUAD   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_X_SEGMENTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SEGMENTS = 2'd1;

  localparam logic [SEG_W-1:0] X_SEG_RESET = 10'd32;
  localparam logic [SEG_W-1:0] Y_SEG_RESET = 10'd16;

  // last of the six index words of a quad
  localparam logic [2:0] QUAD_LAST = 3'd5;

  // Q30 Taylor coefficients of sin(pi/2*t), highest order first
  localparam logic [30:0] KCOEF [6] = '{
    31'd3864, 31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
  };

  typedef struct packed {
    logic             command;
    logic [SEG_W-1:0] column;
    logic [SEG_W-1:0] row;
  } in_word_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;
    logic [IDX_W-1:0]        vertex_index;
    logic                    last;
  } out_word_t;

  typedef struct packed {
    logic             quad;
    logic             last;
    logic [IDX_W-1:0] idx;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
  } mid_t;

endpackage

// ===== sv/usv_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Uses usv_pkg for the divisor width.
module usv_div
  import usv_pkg::*;
#(
  parameter int QB = 17,
  parameter int NW = 27
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [SEG_W-1:0] den_i,
  input  logic [NW-1:0]    num_i,
  output logic [QB-1:0]    quo_o
);

  logic [NW-1:0] rem_q [QB];
  logic [QB-1:0] quo_q [QB];
  logic [NW-1:0] rem_d [QB];
  logic [QB-1:0] quo_d [QB];

  always_comb begin
    logic [NW-1:0] rin;
    logic [QB-1:0] qin;
    logic [NW-1:0] dsh;
    for (int i = 0; i < QB; i++) begin
      rin = (i == 0) ? num_i : rem_q[(i == 0) ? 0 : i-1];
      qin = (i == 0) ? '0 : quo_q[(i == 0) ? 0 : i-1];
      dsh = NW'(den_i) << (QB-1-i);
      if (rin >= dsh) begin
        rem_d[i] = rin - dsh;
        quo_d[i] = qin | (QB'(1) << (QB-1-i));
      end else begin
        rem_d[i] = rin;
        quo_d[i] = qin;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < QB; i++) begin
        rem_q[i] <= rem_d[i];
        quo_q[i] <= quo_d[i];
      end
    end
  end

  assign quo_o = quo_q[QB-1];

endmodule

// ===== sv/uv_sphere_vertex_gen.sv =====
// UV-sphere vertex generator, top level. Uses usv_pkg and usv_div.
// Handshake, quad sequencing, sine pipeline and output register.
//
// A vertex word (command 0) yields one result: unit position (also the
// normal) in Q1.15, texture u/v in Q1.16 and the linear vertex index. A quad
// word (command 1) yields six index words for two triangles, the sixth
// flagged last; the quad word is held on the input while the six entries
// enter the pipeline. Vertex words stream at one per cycle while the output
// is not stalled. The pipeline is one input stage, the divider pipeline (one
// quotient bit per stage, max(17, ANGLE_BITS+1) stages), a fold stage, seven
// polynomial multiply stages, the cross-product stage and the output
// register. The whole pipeline advances whenever the output register is
// empty or taken, so a stall holds every stage in place. Segment counts of
// 0 act as 1. Config writes are always accepted and must happen only while
// idle.
module uv_sphere_vertex_gen
  import usv_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SEG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_word_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_word_t            out_data_o
);

  localparam int QD  = (ANGLE_BITS + 1 > TEX_W) ? ANGLE_BITS + 1 : TEX_W;
  localparam int NW  = SEG_W + QD;
  localparam int NST = QD + 11;
  localparam logic [ANGLE_BITS-1:0] QUARTER   = ANGLE_BITS'(1) << (ANGLE_BITS-2);
  localparam logic [ANGLE_BITS-2:0] QUARTER_R = (ANGLE_BITS-1)'(1) << (ANGLE_BITS-2);

  // ---- configuration registers
  logic [SEG_W-1:0] xseg_q, yseg_q;
  logic [SEG_W-1:0] xs, ys;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xseg_q <= X_SEG_RESET;
      yseg_q <= Y_SEG_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_X_SEGMENTS: xseg_q <= cfg_data_i;
        REG_Y_SEGMENTS: yseg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic [SEG_W-1:0] seg_count(logic [SEG_W-1:0] v);
    if (v == '0) return SEG_W'(1);
    if (32'(v) > MAX_SEGMENTS - 1) return SEG_W'(MAX_SEGMENTS - 1);
    return v;
  endfunction

  assign xs = seg_count(xseg_q);
  assign ys = seg_count(yseg_q);

  // ---- pipeline control: everything moves together
  logic [NST-1:0] vld_q;
  logic           adv;
  logic [2:0]     k_q;
  logic           in_quad;

  assign adv         = out_ready_i || !vld_q[NST-1];
  assign out_valid_o = vld_q[NST-1];
  assign in_quad     = (in_data_i.command == CMD_QUAD);
  assign in_ready_o  = adv && (!in_quad || k_q == QUAD_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      k_q   <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
      if (in_valid_i && in_quad) begin
        k_q <= (k_q == QUAD_LAST) ? 3'd0 : k_q + 3'd1;
      end
    end
  end

  // ---- input stage: clamp, pick grid point for this quad corner
  logic             s0_quad, s0_last;
  logic [SEG_W-1:0] s0_col, s0_row, s0_rsel, s0_csel;

  always_ff @(posedge clk_i) begin
    logic [SEG_W-1:0] xl, yl, c, r;
    logic             hi, inc;
    if (adv) begin
      xl = in_quad ? xs - SEG_W'(1) : xs;
      yl = in_quad ? ys - SEG_W'(1) : ys;
      c  = (in_data_i.column > xl) ? xl : in_data_i.column;
      r  = (in_data_i.row > yl) ? yl : in_data_i.row;
      hi  = 1'b0;
      inc = 1'b0;
      if (in_quad) begin
        case (k_q)
          3'd0, 3'd3: hi = 1'b1;
          3'd1:       ;
          3'd2, 3'd4: inc = 1'b1;
          default: begin
            hi  = 1'b1;
            inc = 1'b1;
          end
        endcase
      end
      s0_quad <= in_quad;
      s0_last <= !in_quad || (k_q == QUAD_LAST);
      s0_col  <= c;
      s0_row  <= r;
      s0_rsel <= r + SEG_W'(hi);
      s0_csel <= c + SEG_W'(inc);
    end
  end

  // ---- dividers: u, v, azimuth and polar phase
  logic [NW-1:0] num_u, num_v, num_a, num_p;
  logic [QD-1:0] quo_u, quo_v, quo_a, quo_p;
  logic [20:0]   idx_full;

  assign num_u = (NW'(s0_col) << 16) + NW'(xs >> 1);
  assign num_v = (NW'(s0_row) << 16) + NW'(ys >> 1);
  assign num_a = (NW'(s0_col) << ANGLE_BITS) + NW'(xs >> 1);
  assign num_p = (NW'(s0_row) << (ANGLE_BITS-1)) + NW'(ys >> 1);
  assign idx_full = 21'(s0_rsel) * 21'(11'(xs) + 11'd1) + 21'(s0_csel);

  usv_div #(.QB(QD), .NW(NW)) u_div_u (
    .clk_i, .en_i(adv), .den_i(xs), .num_i(num_u), .quo_o(quo_u));
  usv_div #(.QB(QD), .NW(NW)) u_div_v (
    .clk_i, .en_i(adv), .den_i(ys), .num_i(num_v), .quo_o(quo_v));
  usv_div #(.QB(QD), .NW(NW)) u_div_a (
    .clk_i, .en_i(adv), .den_i(xs), .num_i(num_a), .quo_o(quo_a));
  usv_div #(.QB(QD), .NW(NW)) u_div_p (
    .clk_i, .en_i(adv), .den_i(ys), .num_i(num_p), .quo_o(quo_p));

  side_t dside_q [QD];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dside_q[0] <= '{quad: s0_quad, last: s0_last, idx: idx_full[IDX_W-1:0]};
      for (int i = 1; i < QD; i++) dside_q[i] <= dside_q[i-1];
    end
  end

  // ---- quadrant fold; lanes: 0 cos az, 1 sin az, 2 cos polar, 3 sin polar
  logic [30:0] t_d   [4];
  logic        neg_d [4];

  always_comb begin
    logic [ANGLE_BITS-1:0] ph [4];
    logic [ANGLE_BITS-2:0] r;
    logic [1:0]            q;
    ph[0] = quo_a[ANGLE_BITS-1:0] + QUARTER;
    ph[1] = quo_a[ANGLE_BITS-1:0];
    ph[2] = quo_p[ANGLE_BITS-1:0] + QUARTER;
    ph[3] = quo_p[ANGLE_BITS-1:0];
    for (int l = 0; l < 4; l++) begin
      q = ph[l][ANGLE_BITS-1 -: 2];
      r = {1'b0, ph[l][ANGLE_BITS-3:0]};
      if (q[0]) r = QUARTER_R - r;
      t_d[l]   = 31'(r) << (32 - ANGLE_BITS);
      neg_d[l] = q[1];
    end
  end

  // ---- odd polynomial, Horner form, one multiply per stage
  logic [30:0] pt_q   [4][7];
  logic [30:0] pt2_q  [4][1:5];
  logic [30:0] pacc_q [4][1:7];
  logic        pneg_q [4][8];
  mid_t        mid_q  [9];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mid_q[0] <= '{side: dside_q[QD-1], tex_u: quo_u[TEX_W-1:0], tex_v: quo_v[TEX_W-1:0]};
      for (int j = 1; j < 9; j++) mid_q[j] <= mid_q[j-1];
      for (int l = 0; l < 4; l++) begin
        pt_q[l][0]   <= t_d[l];
        pneg_q[l][0] <= neg_d[l];
        for (int j = 1; j < 7; j++) pt_q[l][j] <= pt_q[l][j-1];
        for (int j = 1; j < 8; j++) pneg_q[l][j] <= pneg_q[l][j-1];
        pt2_q[l][1]  <= 31'((62'(pt_q[l][0]) * pt_q[l][0]) >> 30);
        for (int j = 2; j < 6; j++) pt2_q[l][j] <= pt2_q[l][j-1];
        pacc_q[l][1] <= KCOEF[0];
        for (int j = 2; j < 7; j++) begin
          pacc_q[l][j] <= KCOEF[j-1] - 31'((62'(pt2_q[l][j-1]) * pacc_q[l][j-1]) >> 30);
        end
        pacc_q[l][7] <= 31'((62'(pt_q[l][6]) * pacc_q[l][6]) >> 30);
      end
    end
  end

  // ---- cross products sin(polar) * cos/sin(azimuth)
  logic [61:0] mx_q, mz_q;
  logic [30:0] my_q;
  logic        nx_q, ny_q, nz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mx_q <= 62'(pacc_q[0][7]) * pacc_q[3][7];
      mz_q <= 62'(pacc_q[1][7]) * pacc_q[3][7];
      my_q <= pacc_q[2][7];
      nx_q <= pneg_q[0][7] ^ pneg_q[3][7];
      nz_q <= pneg_q[1][7] ^ pneg_q[3][7];
      ny_q <= pneg_q[2][7];
    end
  end

  // ---- round to Q1.15 with saturation, output register
  function automatic logic [POS_W-1:0] to_q15(logic [16:0] m, logic neg);
    if (m == '0) return '0;
    if (!neg) return (m > 17'd32767) ? 16'd32767 : m[15:0];
    if (m > 17'd32768) return 16'h8000;
    return 16'(17'd0 - m);
  endfunction

  logic [61:0] rx, rz;
  logic [31:0] ry;
  out_word_t   out_q;

  assign rx = (mx_q + (62'(1) << 44)) >> 45;
  assign rz = (mz_q + (62'(1) << 44)) >> 45;
  assign ry = (32'(my_q) + 32'd16384) >> 15;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (mid_q[8].side.quad) begin
        out_q.pos_x <= '0;
        out_q.pos_y <= '0;
        out_q.pos_z <= '0;
        out_q.tex_u <= '0;
        out_q.tex_v <= '0;
      end else begin
        out_q.pos_x <= to_q15(rx[16:0], nx_q);
        out_q.pos_y <= to_q15(ry[16:0], ny_q);
        out_q.pos_z <= to_q15(rz[16:0], nz_q);
        out_q.tex_u <= mid_q[8].tex_u;
        out_q.tex_v <= mid_q[8].tex_v;
      end
      out_q.vertex_index <= mid_q[8].side.idx;
      out_q.last         <= mid_q[8].side.last;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== tb/sv/tb_uv_sphere_vertex_gen.sv =====
// Self-checking testbench for uv_sphere_vertex_gen: directed table, then
// random vertex/quad words checked against a bit-exact predictor.
// Depends on usv_pkg and the uv_sphere_vertex_gen RTL.
module tb_uv_sphere_vertex_gen;
  import usv_pkg::*;

  localparam int LATENCY   = 40;   // pipeline depth plus margin
  localparam int N_RANDOM  = 95;
  localparam int N_DIRECT  = 16;
  localparam int MAX_SEG_C = 1023;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [SEG_W-1:0]     cfg_data_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_data_o;

  uv_sphere_vertex_gen i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i, .out_valid_o, .out_ready_i, .out_data_o
  );

  always #4 clk_i = ~clk_i;

  // predictor copy of the segment registers
  logic [SEG_W-1:0] xseg_q = X_SEG_RESET;
  logic [SEG_W-1:0] yseg_q = Y_SEG_RESET;

  out_word_t expected_words[$];
  int        n_mismatch = 0;
  bit        drain_hold = 1'b0;   // receiver long hold-off request

  // directed row: word plus optional hand-typed expectation
  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } stim_row_t;

  function automatic longint unsigned seg_eff(logic [SEG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SEG_C) return MAX_SEG_C;
    return v;
  endfunction

  // sin(pi/2*t), Q30 in and out
  function automatic longint unsigned qsine(longint unsigned t);
    longint unsigned t2, acc;
    t2  = (t * t) >> 30;
    acc = KCOEF[0];
    for (int i = 1; i < 6; i++) acc = KCOEF[i] - ((t2 * acc) >> 30);
    return (t * acc) >> 30;
  endfunction

  function automatic void sine_of(input longint unsigned ph,
                                  output longint unsigned mag, output bit neg);
    longint unsigned p, q, r;
    p = ph & 16'hFFFF;
    q = (p >> 14) & 3;
    r = p & 16'h3FFF;
    if (q[0]) r = 16384 - r;
    mag = qsine(r << 16);
    neg = q[1];
  endfunction

  function automatic logic [POS_W-1:0] round_q15(longint unsigned mag, bit neg,
                                                 int sh);
    longint unsigned m;
    m = (mag + (64'd1 << (sh - 1))) >> sh;
    if (m == 0) return '0;
    if (!neg) return (m > 32767) ? 16'sd32767 : m[15:0];
    if (m > 32768) m = 32768;
    return 16'(-m);
  endfunction

  task automatic predict_sphere(in_word_t w);
    longint unsigned xs, ys, col, row, wd, pa, pp, ca, sa, cp, sp, lo, hi;
    bit nca, nsa, ncp, nsp;
    out_word_t o;
    longint unsigned idx[6];
    xs = seg_eff(xseg_q); ys = seg_eff(yseg_q);
    col = w.column; row = w.row; wd = xs + 1;
    if (w.command == CMD_VERTEX) begin
      if (col > xs) col = xs;
      if (row > ys) row = ys;
      pa = ((col * 65536 + xs / 2) / xs) & 16'hFFFF;
      pp = (row * 32768 + ys / 2) / ys;
      sine_of(pa + 16384, ca, nca);
      sine_of(pa, sa, nsa);
      sine_of(pp + 16384, cp, ncp);
      sine_of(pp, sp, nsp);
      o.pos_x = round_q15(ca * sp, nca != nsp, 45);
      o.pos_y = round_q15(cp, ncp, 15);
      o.pos_z = round_q15(sa * sp, nsa != nsp, 45);
      o.tex_u = 17'((col * 65536 + xs / 2) / xs);
      o.tex_v = 17'((row * 65536 + ys / 2) / ys);
      o.vertex_index = 20'(row * wd + col);
      o.last = 1'b1;
      expected_words.insert(expected_words.size(), o);
    end else begin
      if (col > xs - 1) col = xs - 1;
      if (row > ys - 1) row = ys - 1;
      lo = row * wd + col; hi = lo + wd;
      idx = '{hi, lo, lo + 1, hi, lo + 1, hi + 1};
      for (int k = 0; k < 6; k++) begin
        o = '0;
        o.vertex_index = 20'(idx[k]);
        o.last = (k == QUAD_LAST);
        expected_words.insert(expected_words.size(), o);
      end
    end
  endtask

  // idle gap; valid drops only when the gap is not empty
  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 1)) n = 0;
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // one input word; valid held until accepted
  task automatic send_word(in_word_t w);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predict_sphere(w);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_seg(logic [CFG_IDX_W-1:0] idx, logic [SEG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_X_SEGMENTS) xseg_q = val;
    else if (idx == REG_Y_SEGMENTS) yseg_q = val;
    @(posedge clk_i);
  endtask

  function automatic in_word_t mk(logic c, int col, int row);
    in_word_t w;
    w.command = c; w.column = col[9:0]; w.row = row[9:0];
    return w;
  endfunction

  function automatic out_word_t vtx_want(int px, int py, int pz, int u, int v,
                                         int idx);
    out_word_t o;
    o.pos_x = 16'(px); o.pos_y = 16'(py); o.pos_z = 16'(pz);
    o.tex_u = 17'(u); o.tex_v = 17'(v); o.vertex_index = 20'(idx); o.last = 1'b1;
    return o;
  endfunction

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (drain_hold) begin
        out_ready_i <= 1'b0;
        repeat (200) @(posedge clk_i);
        drain_hold = 1'b0;
      end
      if ($urandom_range(0, 40) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(5, 30)) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
      end
    end
  end

  // checker: compare each accepted word to the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected word %p", out_data_o);
      end else begin
        out_word_t e;
        e = expected_words.pop_front();
        if (out_data_o !== e) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("exp %p\n got %p", e, out_data_o);
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("uv_sphere_vertex_gen: mismatch");
    $finish;
  end

  initial begin
    stim_row_t rows[N_DIRECT];
    in_word_t w;
    int n;
    // reset defaults 32/16; typed rows are poles and seam points
    rows[0]  = '{mk(CMD_VERTEX, 0, 0), 1, vtx_want(0, 32767, 0, 0, 0, 0)};
    rows[1]  = '{mk(CMD_VERTEX, 0, 16), 1, vtx_want(0, -32768, 0, 0, 65536, 528)};
    rows[2]  = '{mk(CMD_VERTEX, 0, 8), 0, '0};
    rows[3]  = '{mk(CMD_VERTEX, 8, 8), 0, '0};
    rows[4]  = '{mk(CMD_VERTEX, 16, 8), 0, '0};
    rows[5]  = '{mk(CMD_VERTEX, 24, 5), 0, '0};
    rows[6]  = '{mk(CMD_VERTEX, 32, 8), 0, '0};
    rows[7]  = '{mk(CMD_VERTEX, 1023, 1023), 0, '0};
    rows[8]  = '{mk(CMD_VERTEX, 7, 3), 0, '0};
    rows[9]  = '{mk(CMD_QUAD, 0, 0), 0, '0};
    rows[10] = '{mk(CMD_QUAD, 31, 15), 0, '0};
    rows[11] = '{mk(CMD_QUAD, 1023, 1023), 0, '0};
    rows[12] = '{mk(CMD_QUAD, 682, 341), 0, '0};
    rows[13] = '{mk(CMD_VERTEX, 341, 682), 0, '0};
    rows[14] = '{mk(CMD_QUAD, 5, 9), 0, '0};
    rows[15] = '{mk(CMD_VERTEX, 1, 1), 0, '0};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECT; i++) begin
      send_word(rows[i].word);
      // a typed row overrides the predictor's entry with the hand value
      if (rows[i].typed) expected_words[expected_words.size() - 1] = rows[i].want;
      random_gap();
    end
    wait_idle();

    // register extremes: 0 acts as 1, 1023 is top, then 1, an odd size and a random size
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_seg(REG_X_SEGMENTS, 10'd0);    write_seg(REG_Y_SEGMENTS, 10'd0);    end
        1: begin write_seg(REG_X_SEGMENTS, 10'd1023); write_seg(REG_Y_SEGMENTS, 10'd1023); end
        2: begin write_seg(REG_X_SEGMENTS, 10'd1);    write_seg(REG_Y_SEGMENTS, 10'd1);    end
        3: begin write_seg(REG_X_SEGMENTS, 10'd7);    write_seg(REG_Y_SEGMENTS, 10'd5);    end
        default: begin
          write_seg(REG_X_SEGMENTS, 10'($urandom_range(1, 1023)));
          write_seg(REG_Y_SEGMENTS, 10'($urandom_range(1, 1023)));
        end
      endcase
      write_seg(REG_NONE, 10'($urandom));   // unknown index, ignored
      n = N_RANDOM / 5;
      if (ph == 2) drain_hold = 1'b1;   // long receiver stall this phase
      for (int k = 0; k < n; k++) begin
        w.command = ($urandom_range(0, 3) == 0) ? CMD_QUAD : CMD_VERTEX;
        if ($urandom_range(0, 4) == 0) begin
          w.column = 10'($urandom); w.row = 10'($urandom);
        end else begin
          w.column = 10'($urandom_range(0, 32'(seg_eff(xseg_q))));
          w.row    = 10'($urandom_range(0, 32'(seg_eff(yseg_q))));
        end
        send_word(w);
        if (ph != 2) random_gap();
      end
      // sender pauses until all results are in
      wait_idle();
    end

    if (n_mismatch == 0 && expected_words.size() == 0) begin
      $display("uv_sphere_vertex_gen: match");
    end else begin
      $display("uv_sphere_vertex_gen: mismatch");
    end
    $finish;
  end

endmodule
